// ===== src/b64d_pkg.sv =====
// ----------------------------------------------------------------------------
// b64d_pkg
// Shared types, character codes and helpers for the base64 stream decoder.
// ----------------------------------------------------------------------------
package b64d_pkg;

    localparam int JOB_DEPTH_DEF = 4;

    localparam logic [7:0] CHAR_NUL   = 8'h00;
    localparam logic [7:0] CHAR_PAD   = 8'h3D;  // '='
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;  // '+'
    localparam logic [7:0] CHAR_MINUS = 8'h2D;  // '-'
    localparam logic [7:0] CHAR_SLASH = 8'h2F;  // '/'
    localparam logic [7:0] CHAR_UNDER = 8'h5F;  // '_'
    localparam logic [7:0] CHAR_UC_A  = 8'h41;
    localparam logic [7:0] CHAR_UC_Z  = 8'h5A;
    localparam logic [7:0] CHAR_LC_A  = 8'h61;
    localparam logic [7:0] CHAR_LC_Z  = 8'h7A;
    localparam logic [7:0] CHAR_DIG_0 = 8'h30;
    localparam logic [7:0] CHAR_DIG_9 = 8'h39;

    localparam logic [5:0] SEXTET_62 = 6'd62;
    localparam logic [5:0] SEXTET_63 = 6'd63;

    // Work handed from the front to the back: up to three bytes, then an
    // optional end-of-text status.
    typedef struct packed {
        logic [7:0] data0;
        logic [7:0] data1;
        logic [7:0] data2;
        logic [1:0] byte_cnt;
        logic       has_status;
        logic       bad;
    } t_job;

    // Bit 6 set when the character belongs to either alphabet or is a pad.
    function automatic logic [6:0] f_sextet(input logic [7:0] c);
        logic [6:0] r;
        r = 7'd0;
        if (c >= CHAR_UC_A && c <= CHAR_UC_Z) begin
            r = {1'b1, 6'(c - CHAR_UC_A)};
        end else if (c >= CHAR_LC_A && c <= CHAR_LC_Z) begin
            r = {1'b1, 6'(c - CHAR_LC_A + 8'd26)};
        end else if (c >= CHAR_DIG_0 && c <= CHAR_DIG_9) begin
            r = {1'b1, 6'(c - CHAR_DIG_0 + 8'd52)};
        end else if (c == CHAR_PLUS || c == CHAR_MINUS) begin
            r = {1'b1, SEXTET_62};
        end else if (c == CHAR_SLASH || c == CHAR_UNDER) begin
            r = {1'b1, SEXTET_63};
        end else if (c == CHAR_PAD) begin
            r = {1'b1, 6'd0};
        end
        return r;
    endfunction

    // Bytes produced by a quartet holding the given number of pads.
    function automatic logic [1:0] f_quartet_cnt(input logic [3:0] pads);
        logic [1:0] r;
        if (pads == 4'd0) begin
            r = 2'd3;
        end else if (pads == 4'd1) begin
            r = 2'd2;
        end else begin
            r = 2'd1;
        end
        return r;
    endfunction

endpackage

// ===== src/b64d_front.sv =====
// ----------------------------------------------------------------------------
// b64d_front
// Classifies each text byte, gathers sextets into quartets and posts
// decode jobs (bytes and end status) to the job queue.
// ----------------------------------------------------------------------------
module b64d_front
    import b64d_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic [7:0] i_text,
    input  logic       i_final,
    input  logic       i_room,
    output logic       o_ready,
    output logic       o_push,
    output t_job       o_job
);

    logic [5:0] r_hold [3];
    logic [5:0] n_hold [3];
    logic [1:0] r_fill, n_fill;
    logic [2:0] r_pad, n_pad;
    logic [1:0] r_vcnt, n_vcnt;
    logic       r_any, n_any;
    logic       r_stopped, n_stopped;
    logic       r_ended, n_ended;

    logic       acc;
    logic       ended;
    logic [6:0] sx;
    logic [5:0] s2;
    logic [3:0] pads;

    assign o_ready = i_room;
    assign acc     = i_valid & i_room;

    always_comb begin
        n_hold    = r_hold;
        n_fill    = r_fill;
        n_pad     = r_pad;
        n_vcnt    = r_vcnt;
        n_any     = r_any;
        n_stopped = r_stopped;
        n_ended   = r_ended;
        o_job     = '0;
        o_push    = 1'b0;
        ended     = r_ended | (i_text == CHAR_NUL);
        sx        = f_sextet(i_text);
        s2        = 6'd0;
        pads      = 4'd0;
        if (acc) begin
            n_ended = ended;
            if (!ended && sx[6]) begin
                n_vcnt = r_vcnt + 2'd1;
                n_any  = 1'b1;
                if (!r_stopped) begin
                    if (i_text == CHAR_PAD && r_pad < 3'd4) begin
                        n_pad = r_pad + 3'd1;
                    end
                    unique case (r_fill)
                        2'd0: begin
                            n_hold[0] = sx[5:0];
                            n_fill    = 2'd1;
                        end
                        2'd1: begin
                            n_hold[1] = sx[5:0];
                            n_fill    = 2'd2;
                        end
                        2'd2: begin
                            n_hold[2] = sx[5:0];
                            n_fill    = 2'd3;
                        end
                        default: begin
                            o_job.data0    = {r_hold[0], r_hold[1][5:4]};
                            o_job.data1    = {r_hold[1][3:0], r_hold[2][5:2]};
                            o_job.data2    = {r_hold[2][1:0], sx[5:0]};
                            o_job.byte_cnt = f_quartet_cnt({1'b0, n_pad});
                            o_push         = 1'b1;
                            if (n_pad != 3'd0) begin
                                n_stopped = 1'b1;
                            end
                            n_fill = 2'd0;
                            n_pad  = 3'd0;
                            n_hold = '{default: 6'd0};
                        end
                    endcase
                end
            end
            if (i_final) begin
                // partial quartet of two or three characters: flush as padded
                if (!n_stopped && n_fill >= 2'd2) begin
                    s2   = (n_fill == 2'd3) ? n_hold[2] : 6'd0;
                    pads = {1'b0, n_pad} + 4'd4 - {2'b00, n_fill};
                    o_job.data0    = {n_hold[0], n_hold[1][5:4]};
                    o_job.data1    = {n_hold[1][3:0], s2[5:2]};
                    o_job.data2    = {s2[1:0], 6'd0};
                    o_job.byte_cnt = f_quartet_cnt(pads);
                end
                o_job.has_status = 1'b1;
                o_job.bad        = !n_any || (n_vcnt == 2'd1);
                o_push           = 1'b1;
                n_hold    = '{default: 6'd0};
                n_fill    = 2'd0;
                n_pad     = 3'd0;
                n_vcnt    = 2'd0;
                n_any     = 1'b0;
                n_stopped = 1'b0;
                n_ended   = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold    <= '{default: 6'd0};
            r_fill    <= 2'd0;
            r_pad     <= 3'd0;
            r_vcnt    <= 2'd0;
            r_any     <= 1'b0;
            r_stopped <= 1'b0;
            r_ended   <= 1'b0;
        end else begin
            r_hold    <= n_hold;
            r_fill    <= n_fill;
            r_pad     <= n_pad;
            r_vcnt    <= n_vcnt;
            r_any     <= n_any;
            r_stopped <= n_stopped;
            r_ended   <= n_ended;
        end
    end

    a_stopped_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_stopped |-> (r_fill == 2'd0 && r_pad == 3'd0))
        else $error("quartet state not cleared after decode stop");

    a_pad_le_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pad <= {1'b0, r_fill})
        else $error("pad count exceeds quartet fill");

endmodule

// ===== src/b64d_fifo.sv =====
// ----------------------------------------------------------------------------
// b64d_fifo
// Short job queue between the front and the back.
// ----------------------------------------------------------------------------
module b64d_fifo
    import b64d_pkg::*;
#(
    parameter int DEPTH = JOB_DEPTH_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    input  logic i_pop,
    output t_job o_job,
    output logic o_empty,
    output logic o_room
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_job            r_mem [DEPTH];
    logic [PW-1:0]   r_wr, n_wr;
    logic [PW-1:0]   r_rd, n_rd;
    logic [CW-1:0]   r_cnt, n_cnt;

    assign o_job   = r_mem[r_rd];
    assign o_empty = (r_cnt == CW'(0));
    assign o_room  = (r_cnt != CW'(DEPTH));

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wr = (r_wr == PW'(DEPTH - 1)) ? PW'(0) : r_wr + PW'(1);
        end
        if (i_pop) begin
            n_rd = (r_rd == PW'(DEPTH - 1)) ? PW'(0) : r_rd + PW'(1);
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + CW'(1);
        end else if (i_pop && !i_push) begin
            n_cnt = r_cnt - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> o_room)
        else $error("job queue overflow");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty)
        else $error("job queue underflow");

endmodule

// ===== src/b64d_back.sv =====
// ----------------------------------------------------------------------------
// b64d_back
// Takes jobs from the queue and plays them out as one result word per
// cycle while the receiver is ready: the decoded bytes, then the end status if the job has one.
// ----------------------------------------------------------------------------
module b64d_back
    import b64d_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_job       i_job,
    input  logic       i_empty,
    output logic       o_pop,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_data,
    output logic       o_carries,
    output logic       o_eot,
    output logic       o_bad,
    output logic       o_last
);

    t_job       r_cur;
    logic       r_busy, n_busy;
    logic [1:0] r_idx, n_idx;
    logic [2:0] total;
    logic       fire;
    logic       is_byte;

    assign total   = {1'b0, r_cur.byte_cnt} + {2'b00, r_cur.has_status};
    assign o_last  = ({1'b0, r_idx} == total - 3'd1);
    assign fire    = r_busy & i_ready;
    assign o_valid = r_busy;
    assign o_pop   = !i_empty && (!r_busy || (fire && o_last));
    assign is_byte = (r_idx < r_cur.byte_cnt);

    always_comb begin
        unique case (r_idx)
            2'd0:    o_data = r_cur.data0;
            2'd1:    o_data = r_cur.data1;
            default: o_data = r_cur.data2;
        endcase
        if (!is_byte) begin
            o_data = 8'd0;
        end
    end

    assign o_carries = is_byte;
    assign o_eot     = !is_byte;
    assign o_bad     = !is_byte & r_cur.bad;

    always_comb begin
        n_busy = r_busy;
        n_idx  = r_idx;
        if (o_pop) begin
            n_busy = 1'b1;
            n_idx  = 2'd0;
        end else if (fire) begin
            if (o_last) begin
                n_busy = 1'b0;
                n_idx  = 2'd0;
            end else begin
                n_idx = r_idx + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cur <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= 2'd0;
        end else begin
            r_busy <= n_busy;
            r_idx  <= n_idx;
        end
    end

    a_idx_in_job: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> ({1'b0, r_idx} < total))
        else $error("result index beyond job length");

endmodule

// ===== src/base64_stream_decoder.sv =====
// ----------------------------------------------------------------------------
// base64_stream_decoder
// Base64 text to byte stream decoder, standard and URL alphabets.
// ----------------------------------------------------------------------------
// Input channel s_axis: one text character per word in tdata, tlast on the
// last character of a text. Output channel m_axis: one result per word;
// tdata is the decoded byte, tuser flags the kind of word, tlast marks the
// last result caused by one input character.
// A closing status word (end flag set, no byte) follows the last character;
// its bad-length flag asks the receiver to drop the bytes of that text.
// Throughput: one character per cycle while the job queue has room; a quartet
// yields up to three byte words, played out in turn on the single output port.
// The job of a character is written into the job queue, then loaded into the
// result register of the back stage, from which its results are shown.
// A short job queue between front and back absorbs bursts; s_axis_tready
// drops only when that queue is full, e.g. while m_axis is stalled.
// Reset clears all decode state and the queue; no result is pending after.
// ----------------------------------------------------------------------------
module base64_stream_decoder
    import b64d_pkg::*;
#(
    parameter int JOB_DEPTH = JOB_DEPTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] text_byte
    input  logic       s_axis_tlast,   // final_char
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] data_byte
    output logic [2:0] m_axis_tuser,   // [0] carries_byte [1] end_of_text [2] bad_length
    output logic       m_axis_tlast    // run_end
);

    logic push;
    logic pop;
    logic empty;
    logic room;
    t_job job_in;
    t_job job_out;

    b64d_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .i_text  (s_axis_tdata),
        .i_final (s_axis_tlast),
        .i_room  (room),
        .o_ready (s_axis_tready),
        .o_push  (push),
        .o_job   (job_in)
    );

    b64d_fifo #(
        .DEPTH (JOB_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (job_in),
        .i_pop   (pop),
        .o_job   (job_out),
        .o_empty (empty),
        .o_room  (room)
    );

    b64d_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_job     (job_out),
        .i_empty   (empty),
        .o_pop     (pop),
        .o_valid   (m_axis_tvalid),
        .i_ready   (m_axis_tready),
        .o_data    (m_axis_tdata),
        .o_carries (m_axis_tuser[0]),
        .o_eot     (m_axis_tuser[1]),
        .o_bad     (m_axis_tuser[2]),
        .o_last    (m_axis_tlast)
    );

endmodule

// ===== tb/base64_decode_checker.sv =====
// ----------------------------------------------------------------------------
// base64_decode_checker
// Watches both stream channels of the base64 stream decoder. Each character
// word taken on s_axis runs through a decode model; the words it should
// cause are queued and compared field by field with the words on m_axis.
// ----------------------------------------------------------------------------
module base64_decode_checker
    import b64d_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       s_axis_tvalid,
    input  logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] text_byte
    input  logic       s_axis_tlast,   // final_char
    input  logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    input  logic [7:0] m_axis_tdata,   // [7:0] data_byte
    input  logic [2:0] m_axis_tuser,   // [0] carries_byte [1] end_of_text [2] bad_length
    input  logic       m_axis_tlast,   // run_end
    output int         o_fail_count,
    output int         o_pending
);

    typedef struct packed {
        logic [7:0] data_byte;
        logic       carries_byte;
        logic       end_of_text;
        logic       bad_length;
        logic       run_end;
    } decoded_word_t;

    decoded_word_t expected_words[$];
    decoded_word_t char_words[4];
    int            char_word_cnt;

    logic [5:0] held_sextets[3];
    logic [1:0] quartet_fill;
    logic [2:0] pad_count;
    logic [1:0] valid_mod4;
    logic       seen_valid;
    logic       decode_halted;
    logic       text_closed;

    int fail_total = 0;
    int pending_words = 0;

    assign o_fail_count = fail_total;
    assign o_pending    = pending_words;

    // {valid, sextet}
    function automatic logic [6:0] sextet_lookup(input logic [7:0] c);
        logic [6:0] r;
        case (c) inside
            [CHAR_UC_A:CHAR_UC_Z]:   r = {1'b1, 6'(c - CHAR_UC_A)};
            [CHAR_LC_A:CHAR_LC_Z]:   r = {1'b1, 6'(c - CHAR_LC_A + 8'd26)};
            [CHAR_DIG_0:CHAR_DIG_9]: r = {1'b1, 6'(c - CHAR_DIG_0 + 8'd52)};
            CHAR_PLUS, CHAR_MINUS:   r = {1'b1, SEXTET_62};
            CHAR_SLASH, CHAR_UNDER:  r = {1'b1, SEXTET_63};
            CHAR_PAD:                r = {1'b1, 6'd0};
            default:                 r = 7'd0;
        endcase
        return r;
    endfunction

    task automatic clear_decode_state();
        held_sextets  = '{default: 6'd0};
        quartet_fill  = 2'd0;
        pad_count     = 3'd0;
        valid_mod4    = 2'd0;
        seen_valid    = 1'b0;
        decode_halted = 1'b0;
        text_closed   = 1'b0;
    endtask

    task automatic add_word(input logic [7:0] data, input logic carries,
                            input logic eot, input logic bad);
        char_words[char_word_cnt] = '{data, carries, eot, bad, 1'b0};
        char_word_cnt++;
    endtask

    task automatic add_quartet(input logic [5:0] s0, input logic [5:0] s1,
                               input logic [5:0] s2, input logic [5:0] s3,
                               input int pads);
        add_word({s0, s1[5:4]}, 1'b1, 1'b0, 1'b0);
        if (pads < 2) begin
            add_word({s1[3:0], s2[5:2]}, 1'b1, 1'b0, 1'b0);
        end
        if (pads < 1) begin
            add_word({s2[1:0], s3}, 1'b1, 1'b0, 1'b0);
        end
    endtask

    task automatic decode_char(input logic [7:0] c, input logic is_last);
        logic [6:0]    sx;
        logic [5:0]    s2;
        decoded_word_t w;
        char_word_cnt = 0;
        if (!text_closed && c == CHAR_NUL) begin
            text_closed = 1'b1;
        end
        if (!text_closed) begin
            sx = sextet_lookup(c);
            if (sx[6]) begin
                valid_mod4 = valid_mod4 + 2'd1;
                seen_valid = 1'b1;
                if (!decode_halted) begin
                    if (c == CHAR_PAD && pad_count < 3'd4) begin
                        pad_count = pad_count + 3'd1;
                    end
                    if (quartet_fill < 2'd3) begin
                        held_sextets[quartet_fill] = sx[5:0];
                        quartet_fill = quartet_fill + 2'd1;
                    end else begin
                        add_quartet(held_sextets[0], held_sextets[1], held_sextets[2],
                                    sx[5:0], int'(pad_count));
                        if (pad_count != 3'd0) begin
                            decode_halted = 1'b1;
                        end
                        quartet_fill = 2'd0;
                        pad_count    = 3'd0;
                        held_sextets = '{default: 6'd0};
                    end
                end
            end
        end
        if (is_last) begin
            // partial quartet is flushed as if padded
            if (!decode_halted && quartet_fill >= 2'd2) begin
                s2 = (quartet_fill == 2'd3) ? held_sextets[2] : 6'd0;
                add_quartet(held_sextets[0], held_sextets[1], s2, 6'd0,
                            int'(pad_count) + 4 - int'(quartet_fill));
            end
            add_word(8'd0, 1'b0, 1'b1, !seen_valid || valid_mod4 == 2'd1);
            clear_decode_state();
        end
        for (int i = 0; i < char_word_cnt; i++) begin
            w = char_words[i];
            w.run_end = (i == char_word_cnt - 1);
            expected_words.push_back(w);
        end
    endtask

    always @(posedge i_clk) begin
        decoded_word_t exp_word;
        if (!i_rst_n) begin
            clear_decode_state();
            expected_words.delete();
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                decode_char(s_axis_tdata, s_axis_tlast);
            end
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_words.size() == 0) begin
                    $error("unexpected word: data_byte %0h tuser %03b tlast %0b",
                           m_axis_tdata, m_axis_tuser, m_axis_tlast);
                    fail_total++;
                end else begin
                    exp_word = expected_words.pop_front();
                    if (m_axis_tdata !== exp_word.data_byte) begin
                        $error("data_byte: expected %02h, got %02h",
                               exp_word.data_byte, m_axis_tdata);
                        fail_total++;
                    end
                    if (m_axis_tuser[0] !== exp_word.carries_byte) begin
                        $error("carries_byte: expected %0b, got %0b",
                               exp_word.carries_byte, m_axis_tuser[0]);
                        fail_total++;
                    end
                    if (m_axis_tuser[1] !== exp_word.end_of_text) begin
                        $error("end_of_text: expected %0b, got %0b",
                               exp_word.end_of_text, m_axis_tuser[1]);
                        fail_total++;
                    end
                    if (m_axis_tuser[2] !== exp_word.bad_length) begin
                        $error("bad_length: expected %0b, got %0b",
                               exp_word.bad_length, m_axis_tuser[2]);
                        fail_total++;
                    end
                    if (m_axis_tlast !== exp_word.run_end) begin
                        $error("run_end: expected %0b, got %0b",
                               exp_word.run_end, m_axis_tlast);
                        fail_total++;
                    end
                end
            end
        end
        pending_words = expected_words.size();
    end

endmodule

// ===== tb/base64_stream_decoder_test.sv =====
// ----------------------------------------------------------------------------
// base64_stream_decoder_test
// Feeds the base64 stream decoder with directed texts (both alphabets, pads,
// skipped bytes, zero byte, short tails) and then with random texts, mostly
// well formed with noise mixed in. Both sides idle at random and the
// receiver stalls for long stretches to fill the decoder. The checker
// beside the decoder predicts and compares every output word.
// ----------------------------------------------------------------------------
module base64_stream_decoder_test;
    import b64d_pkg::*;

    localparam int TEXT_CHARS   = 325;
    localparam int LIMIT_CYCLES = 300000;
    localparam int LONG_HOLD    = 300;
    localparam int TAIL_CYCLES  = 12;
    localparam string ALPHABET =
        "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/-_";

    logic       i_clk;
    logic       i_rst_n;
    logic       s_axis_tvalid;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata;   // [7:0] text_byte
    logic       s_axis_tlast;   // final_char
    logic       m_axis_tvalid;
    logic       m_axis_tready;
    logic [7:0] m_axis_tdata;   // [7:0] data_byte
    logic [2:0] m_axis_tuser;   // [0] carries_byte [1] end_of_text [2] bad_length
    logic       m_axis_tlast;   // run_end

    int fail_count;
    int pending_words;
    int chars_sent = 0;
    int cycle_cnt  = 0;
    logic       tx_idle;
    logic [7:0] text[$];

    base64_stream_decoder DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    base64_decode_checker checker_i (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .o_fail_count  (fail_count),
        .o_pending     (pending_words)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > LIMIT_CYCLES) begin
            $display("FAIL base64_stream_decoder");
            $finish;
        end
    end

    // receiver: random stalls, steady stretches, and two long hold-offs
    initial begin
        int   words_taken;
        int   gap;
        logic rx_idle;
        words_taken   = 0;
        rx_idle       = 1'b1;
        m_axis_tready = 1'b0;
        @(posedge i_rst_n);
        @(negedge i_clk);
        forever begin
            if (words_taken % 48 == 0) begin
                rx_idle = ($urandom_range(0, 3) != 0);
            end
            if (words_taken == 40 || words_taken == 180) begin
                gap = LONG_HOLD;
            end else begin
                gap = rx_idle ? $urandom_range(0, 17) : 0;
            end
            if (gap > 0) begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
            words_taken++;
            @(negedge i_clk);
        end
    end

    task automatic send_char(input logic [7:0] c, input logic is_last);
        int gap;
        gap = tx_idle ? $urandom_range(0, 17) : 0;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= c;
        s_axis_tlast  <= is_last;
        do @(posedge i_clk); while (!s_axis_tready);
        chars_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_text();
        tx_idle = ($urandom_range(0, 3) != 0);
        for (int i = 0; i < text.size(); i++) begin
            send_char(text[i], i == text.size() - 1);
        end
    endtask

    task automatic send_string(input string s);
        text.delete();
        for (int i = 0; i < s.len(); i++) begin
            text.push_back(s[i]);
        end
        send_text();
    endtask

    function automatic logic [7:0] pick_char();
        return ALPHABET[$urandom_range(0, ALPHABET.len() - 1)];
    endfunction

    task automatic build_random_text();
        int shape;
        int quartets;
        int tail;
        text.delete();
        shape    = $urandom_range(0, 19);
        quartets = ($urandom_range(0, 7) == 0) ? $urandom_range(4, 8) : $urandom_range(0, 3);
        tail     = $urandom_range(0, 3);
        repeat (quartets * 4 + tail) text.push_back(pick_char());
        if (tail >= 2 && $urandom_range(0, 1) == 1) begin
            repeat (4 - tail) text.push_back(CHAR_PAD);
        end else if (tail == 0 && quartets > 0 && $urandom_range(0, 2) == 0) begin
            text[text.size() - 1] = CHAR_PAD;
            if ($urandom_range(0, 1) == 1) begin
                text[text.size() - 2] = CHAR_PAD;
            end
        end
        case (shape)
            0, 1, 2: begin
                repeat ($urandom_range(1, 3)) begin
                    text.insert($urandom_range(0, text.size()), 8'($urandom_range(1, 255)));
                end
            end
            3: text.insert($urandom_range(0, text.size()), CHAR_NUL);
            4: begin
                text.delete();
                repeat ($urandom_range(1, 10)) text.push_back(8'($urandom_range(0, 255)));
            end
            5: repeat ($urandom_range(1, 5)) text.push_back(pick_char());
            6: repeat ($urandom_range(1, 3)) text.push_back(CHAR_PAD);
            default: ;
        endcase
        if (text.size() == 0) begin
            text.push_back(8'($urandom_range(0, 255)));
        end
    endtask

    initial begin
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = 8'd0;
        s_axis_tlast  = 1'b0;
        tx_idle       = 1'b1;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        send_string("A9+/");
        send_string("a-_=");
        send_string("Zw==Q");     // stop after pads, trailing char gives 1 mod 4
        send_string("QUJ");
        send_string("Q");
        text = '{8'h54, 8'hFF, 8'h2A, 8'h57};
        send_text();
        text = '{8'h51, 8'h55, CHAR_NUL, 8'h5A};
        send_text();
        text = '{8'h80};
        send_text();

        while (chars_sent < TEXT_CHARS) begin
            build_random_text();
            send_text();
        end
        s_axis_tvalid <= 1'b0;
        s_axis_tlast  <= 1'b0;

        while (pending_words != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("PASS base64_stream_decoder");
        end else begin
            $display("FAIL base64_stream_decoder");
        end
        $finish;
    end

endmodule
